>>> sv/bounded_ordered_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list engine
// Shorthand for clocked assertions, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// consequent checked in the same cycle
`define BOLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define BOLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bole_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Field widths, command and status codes, cell control and sequencer types.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int CMD_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK    = 4'd0,
    CMD_PUSH_FRONT   = 4'd1,
    CMD_INSERT_AT    = 4'd2,
    CMD_POP_BACK     = 4'd3,
    CMD_POP_FRONT    = 4'd4,
    CMD_POP_PARITY   = 4'd5,
    CMD_FIND         = 4'd6,
    CMD_REMOVE_VALUE = 4'd7,
    CMD_REMOVE_AT    = 4'd8
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     search;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_APPLY,
    S_DONE
  } state_t;

endpackage

>>> sv/bole_req_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one list command per item.
// ----------------------------------------------------------------------------
interface bole_req_if import bole_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

>>> sv/bole_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one command result per item.
// ----------------------------------------------------------------------------
interface bole_rsp_if import bole_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] out_value;
  logic [FOUND_W-1:0]        found_position;
  logic [COUNT_W-1:0]        element_count;

  modport source (output valid, status, out_value, found_position, element_count,
                  input ready);
  modport sink (input valid, status, out_value, found_position, element_count,
                output ready);
endinterface

>>> sv/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered list of signed 32-bit values with end, indexed and search commands.
// ----------------------------------------------------------------------------
// Each command runs through a sequence of steps: the row of cells compares
// every element with the command value on the accepting edge, the sequencer
// then picks the first match and checks count and position, the whole row
// shifts in one step to open or close a gap, and the result is loaded into
// the response register. A new command is taken only once the previous one
// has reached that register. A response left waiting holds the following
// command in its last step. A failed command leaves the list as it was. Cell
// contents need no clearing after reset.
module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int FW = (IW > FOUND_W) ? IW : FOUND_W;
  localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;

  state_t                    state, state_next;
  cmd_t                      cmd_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]          pos_q;
  logic [CW-1:0]             count;
  cell_op_t                  op_q;
  logic [IW-1:0]             at_q;
  status_t                   status_q;
  logic [IW-1:0]             found_q;
  logic signed [VALUE_W-1:0] removed_q;

  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_data;
  logic [FOUND_W-1:0]        out_found;
  logic [COUNT_W-1:0]        out_count;

  logic signed [VALUE_W-1:0] data [CAPACITY];
  logic [CAPACITY-1:0]       match;
  logic [CAPACITY-1:0]       first;
  logic [IW-1:0]             first_idx;
  logic                      hit;
  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] key;

  status_t                   d_status;
  cell_op_t                  d_op;
  logic [IW-1:0]             d_at;
  logic [IW-1:0]             d_found;
  logic [XW-1:0]             count_x;
  logic [XW-1:0]             pos_x;
  logic                      full;
  logic                      empty;
  logic [FW-1:0]             found_x;
  logic [KW-1:0]             count_k;
  logic                      out_load;

  // ---------------------------------------------------------------- cell row
  assign ctrl.search = (state == S_IDLE);
  assign ctrl.op     = (state == S_APPLY) ? op_q : CELL_HOLD;
  assign key         = (state == S_IDLE) ? req.value : value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bole_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .at        (at_q),
      .count     (count),
      .key       (key),
      .prev_data ((i == 0) ? data[i] : data[(i == 0) ? 0 : i - 1]),
      .next_data ((i == CAPACITY - 1) ? data[i] : data[(i == CAPACITY - 1) ? i : i + 1]),
      .data      (data[i]),
      .match     (match[i])
    );
  end

  // ------------------------------------------------------------ first match
  assign first = match & (~match + 1'b1);
  assign hit   = |match;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        first_idx = first_idx | IW'(i);
      end
    end
  end

  // ------------------------------------------------------------------ decide
  assign count_x = XW'(count);
  assign pos_x   = XW'(pos_q);
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);

  always_comb begin
    d_status = ST_OK;
    d_op     = CELL_HOLD;
    d_at     = '0;
    d_found  = '0;
    case (cmd_q)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
        if (full) begin
          d_status = ST_FULL;
        end else if (cmd_q == CMD_PUSH_BACK) begin
          d_op = CELL_OPEN;
          d_at = IW'(count);
        end else if (cmd_q == CMD_PUSH_FRONT) begin
          d_op = CELL_OPEN;
        end else if (pos_x > count_x) begin
          d_status = ST_RANGE;
        end else begin
          d_op = CELL_OPEN;
          d_at = IW'(pos_x);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT, CMD_POP_PARITY: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else begin
          d_op = CELL_CLOSE;
          if (!((cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_PARITY && count[0]))) begin
            d_at = IW'(count - 1'b1);
          end
        end
      end
      CMD_FIND, CMD_REMOVE_VALUE: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else if (!hit) begin
          d_status = ST_MISSING;
        end else begin
          d_found = first_idx;
          if (cmd_q == CMD_REMOVE_VALUE) begin
            d_op = CELL_CLOSE;
            d_at = first_idx;
          end
        end
      end
      CMD_REMOVE_AT: begin
        if (empty) begin
          d_status = ST_EMPTY;
        end else if (pos_x >= count_x) begin
          d_status = ST_RANGE;
        end else begin
          d_op = CELL_CLOSE;
          d_at = IW'(pos_x);
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------- sequencer
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = S_APPLY;
      S_APPLY:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_APPLY) begin
      case (op_q)
        CELL_OPEN:  count <= count + 1'b1;
        CELL_CLOSE: count <= count - 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q   <= cmd_t'(req.cmd);
      value_q <= req.value;
      pos_q   <= req.position;
    end
    if (state == S_DECIDE) begin
      status_q <= d_status;
      op_q     <= d_op;
      at_q     <= d_at;
      found_q  <= d_found;
    end
    if (state == S_APPLY) begin
      removed_q <= (op_q == CELL_CLOSE) ? data[at_q] : '0;
    end
  end

  // ---------------------------------------------------------- response item
  assign found_x = FW'(found_q);
  assign count_k = KW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_q;
      out_data   <= removed_q;
      out_found  <= found_x[FOUND_W-1:0];
      out_count  <= count_k[COUNT_W-1:0];
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.out_value      = out_data;
  assign rsp.found_position = out_found;
  assign rsp.element_count  = out_count;

endmodule

>>> sv/bole_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one list element; shifts from a neighbour, loads, and compares.
// ----------------------------------------------------------------------------
module bole_cell import bole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX      = 0,
  localparam int IW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic [IW-1:0]             at,
  input  logic [CW-1:0]             count,
  input  logic signed [VALUE_W-1:0] key,
  input  logic signed [VALUE_W-1:0] prev_data,
  input  logic signed [VALUE_W-1:0] next_data,
  output logic signed [VALUE_W-1:0] data,
  output logic                      match
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_OPEN: begin
        if (MY_IDX == at) begin
          data <= key;
        end else if (MY_IDX > at) begin
          data <= prev_data;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= at) begin
          data <= next_data;
        end
      end
      default: begin
      end
    endcase
  end

  // only occupied cells may match
  always_ff @(posedge clk) begin
    if (ctrl.search) begin
      match <= (data == key) && (MY_CNT < count);
    end
  end

endmodule

>>> sv/bole_checker.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_engine_defines.svh"

module bole_checker import bole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [STATUS_W-1:0]       rsp_status,
  input logic signed [VALUE_W-1:0] rsp_out_value,
  input logic [FOUND_W-1:0]        rsp_found_position,
  input logic [COUNT_W-1:0]        rsp_element_count
);

  `BOLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_value) && $stable(rsp_element_count), "response changed while stalled")
  `BOLE_ASSERT_NOW(a_fail_no_value, rsp_valid && rsp_status != ST_OK, rsp_out_value == '0, "failed command returned an element")
  `BOLE_ASSERT_NOW(a_empty_count, rsp_valid && rsp_status == ST_EMPTY, rsp_element_count == '0, "empty status with elements stored")
  `BOLE_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_element_count == COUNT_W'(CAPACITY), "full status below capacity")
  `BOLE_ASSERT_NOW(a_found_ok, rsp_valid && rsp_found_position != '0, rsp_status == ST_OK, "match position on a failed command")

endmodule

bind bounded_ordered_list_engine bole_checker #(
  .CAPACITY (CAPACITY)
) u_bole_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_out_value      (rsp.out_value),
  .rsp_found_position (rsp.found_position),
  .rsp_element_count  (rsp.element_count)
);

>>> tb/sv/bole_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// List engine checker
// Watches the command and response channels and keeps a shadow copy of the
// list. Each accepted command is applied to the shadow to form the expected
// result, which is queued and compared field by field with the next accepted
// response. Outputs the running mismatch count and the number of results
// still outstanding.
// ----------------------------------------------------------------------------
module bole_list_checker import bole_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  bole_req_if  req,
  bole_rsp_if  rsp,
  output int   mismatches,
  output int   waiting
);

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  removed;
    logic [FOUND_W-1:0]  hit_pos;
    logic [COUNT_W-1:0]  size;
  } list_result_t;

  logic [VALUE_W-1:0] slots [CAPACITY];
  int                 fill;
  int                 fails;
  list_result_t       expected_results [$];

  initial begin
    fill       = 0;
    fails      = 0;
    mismatches = 0;
    waiting    = 0;
  end

  task automatic report(input string field, input logic [VALUE_W-1:0] got,
                        input logic [VALUE_W-1:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $time, field, got, want);
    fails++;
  endtask

  function automatic logic [VALUE_W-1:0] close_slot(input int at);
    logic [VALUE_W-1:0] v;
    v = slots[at];
    for (int i = at; i + 1 < fill; i++) slots[i] = slots[i + 1];
    fill--;
    return v;
  endfunction

  function automatic list_result_t apply_command(input logic [CMD_W-1:0] code,
                                                 input logic [VALUE_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           at;
    bit           hit;
    r        = '0;
    r.status = ST_OK;
    case (code)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
        if (fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (code == CMD_INSERT_AT && pos > fill) begin
          r.status = ST_RANGE;
        end else begin
          at = (code == CMD_PUSH_BACK) ? fill : (code == CMD_PUSH_FRONT) ? 0 : int'(pos);
          for (int i = fill; i > at; i--) slots[i] = slots[i - 1];
          slots[at] = val;
          fill++;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT, CMD_POP_PARITY: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (code == CMD_POP_FRONT || (code == CMD_POP_PARITY && fill % 2 == 1)) begin
          r.removed = close_slot(0);
        end else begin
          r.removed = close_slot(fill - 1);
        end
      end
      CMD_FIND, CMD_REMOVE_VALUE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = 1'b0;
          at  = 0;
          for (int i = 0; i < fill && !hit; i++) begin
            if (slots[i] == val) begin
              hit = 1'b1;
              at  = i;
            end
          end
          if (!hit) begin
            r.status = ST_MISSING;
          end else begin
            r.hit_pos = FOUND_W'(at);
            if (code == CMD_REMOVE_VALUE) r.removed = close_slot(at);
          end
        end
      end
      CMD_REMOVE_AT: begin
        if (fill == 0) r.status = ST_EMPTY;
        else if (pos >= fill) r.status = ST_RANGE;
        else r.removed = close_slot(int'(pos));
      end
      default: ;
    endcase
    r.size = COUNT_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      fill = 0;
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_command(req.cmd, req.value, req.position));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("response with no command outstanding", VALUE_W'(rsp.status), '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) begin
            report("status", VALUE_W'(rsp.status), VALUE_W'(want.status));
          end
          if (rsp.out_value !== want.removed) report("out_value", rsp.out_value, want.removed);
          if (rsp.found_position !== want.hit_pos) begin
            report("found_position", VALUE_W'(rsp.found_position), VALUE_W'(want.hit_pos));
          end
          if (rsp.element_count !== want.size) begin
            report("element_count", VALUE_W'(rsp.element_count), VALUE_W'(want.size));
          end
        end
      end
    end
    mismatches <= fails;
    waiting    <= expected_results.size();
  end

endmodule

>>> tb/sv/bounded_ordered_list_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// List engine testbench
// Drives a directed sequence of edge cases (empty list, bad positions,
// missing values, parity pops, unknown commands, extreme values)
// and then biased random commands that grow and drain the list, under three
// handshake regimes: slow sender with a mostly stalled receiver, the reverse,
// and no idling. Results are checked by the checker module beside the block.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam int ITEMS_PER_PHASE = 134;
  localparam int IDLE_LIMIT      = 5000;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   stall_pct;
  int   quiet_cycles;
  int   mismatches;
  int   waiting;

  bole_req_if req ();
  bole_rsp_if rsp ();

  bounded_ordered_list_engine u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  bole_list_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // no progress on either channel for too long
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] val,
                       input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.cmd      <= code;
    req.value    <= val;
    req.position <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input int grow_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_W'($urandom_range(CMD_REMOVE_AT + 1, (1 << CMD_W) - 1));
    if ($urandom_range(0, 99) < grow_pct) return CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_INSERT_AT));
    return CMD_W'($urandom_range(CMD_POP_BACK, CMD_REMOVE_AT));
  endfunction

  // small pool and extremes so that searches hit and duplicates occur
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return VALUE_W'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 2))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return -VALUE_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 80) return POS_W'($urandom_range(0, CAPACITY_DEF));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  initial begin
    int grow_pct;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.cmd       = '0;
    req.value     = '0;
    req.position  = '0;
    rsp.ready     = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 27;
    stall_pct     = 80;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list
    issue(CMD_POP_BACK, 32'h0, 5'd0);
    issue(CMD_POP_FRONT, 32'h0, 5'd0);
    issue(CMD_POP_PARITY, 32'h0, 5'd0);
    issue(CMD_FIND, 32'h0, 5'd0);
    issue(CMD_REMOVE_VALUE, 32'h0, 5'd0);
    issue(CMD_REMOVE_AT, 32'h0, 5'd0);
    issue(CMD_INSERT_AT, 32'h1, 5'd1);
    // build and probe
    issue(CMD_INSERT_AT, 32'h7fff_ffff, 5'd0);
    issue(CMD_PUSH_BACK, 32'h8000_0000, 5'd0);
    issue(CMD_PUSH_FRONT, 32'hffff_ffff, 5'd31);
    issue(CMD_INSERT_AT, 32'h0, 5'd3);
    issue(CMD_INSERT_AT, 32'h5, 5'd31);
    issue(CMD_FIND, 32'h8000_0000, 5'd0);
    issue(CMD_FIND, 32'h5, 5'd0);
    issue(CMD_REMOVE_VALUE, 32'h7fff_ffff, 5'd0);
    issue(CMD_REMOVE_AT, 32'h0, 5'd3);
    issue(CMD_REMOVE_AT, 32'h0, 5'd31);
    issue(CMD_REMOVE_AT, 32'h0, 5'd1);
    issue(CMD_POP_PARITY, 32'h0, 5'd0);
    issue(CMD_POP_PARITY, 32'h0, 5'd0);
    issue(CMD_REMOVE_AT + 4'd1, 32'hffff_ffff, 5'd31);
    issue({CMD_W{1'b1}}, 32'h0, 5'd0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 80 : 0;
      stall_pct     = (phase == 0) ? 80 : (phase == 1) ? 27 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(0, 2))
            0: grow_pct = 80;
            1: grow_pct = 20;
            default: grow_pct = 50;
          endcase
        end
        issue(pick_command(grow_pct), pick_value(), pick_position());
      end
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
